>>> rtl/lgi_pkg.sv
package lgi_pkg;

    // sample format and gap limit
    localparam int SAMPLE_WIDTH = 32;
    localparam int MAX_GAP      = 31;

    // fixed field width on the stream
    localparam int DATA_W  = 32;
    // signed difference of two samples
    localparam int DIFF_W  = SAMPLE_WIDTH + 1;
    // pending missing count, 0..MAX_GAP
    localparam int GAP_W   = $clog2(MAX_GAP + 1);
    // divisor, gap length plus one, up to MAX_GAP + 1
    localparam int DIV_W   = $clog2(MAX_GAP + 2);
    // divider step counter, holds DIFF_W
    localparam int DCNT_W  = $clog2(DIFF_W + 1);
    // result flags in m_tuser
    localparam int OUSER_W = 4;

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic [GAP_W-1:0] gap_t;
    typedef logic [DIV_W-1:0] divisor_t;

    // kind of result the datapath puts in the output register
    typedef enum logic [1:0] {
        EK_FILL = 2'd0,
        EK_GAP  = 2'd1,
        EK_LAST = 2'd2
    } emit_kind_t;

    // commands from the controller
    typedef struct packed {
        logic       load;
        logic       bump;
        logic       div_start;
        logic       fill_init;
        logic       emit;
        emit_kind_t kind;
        logic       commit;
    } cmd_t;

    // status back to the controller
    typedef struct packed {
        logic seen;
        logic overlong;
        logic pend_zero;
        logic pend_max;
        logic cnt_one;
        logic out_free;
        logic div_done;
        logic div_busy;
    } stat_t;

endpackage

>>> rtl/lgi_div.sv
module lgi_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  lgi_pkg::diff_t           dividend,
    input  lgi_pkg::divisor_t        divisor,
    output logic                     busy,
    output logic                     done,
    output lgi_pkg::diff_t           quot,
    output lgi_pkg::divisor_t        rem
);

    logic                          busy_reg, busy_next;
    logic                          fix_reg, fix_next;
    logic                          done_reg, done_next;
    logic [lgi_pkg::DCNT_W-1:0]    cnt_reg, cnt_next;
    logic                          neg_reg;
    logic [lgi_pkg::DIFF_W-1:0]    quo_reg;
    lgi_pkg::divisor_t             acc_reg;
    lgi_pkg::diff_t                quot_reg;
    lgi_pkg::divisor_t             rem_reg;
    logic [lgi_pkg::DIV_W:0]       part;
    logic                          fits;
    logic [lgi_pkg::DIFF_W-1:0]    mag;

    // magnitude of the dividend at start
    assign mag = dividend[lgi_pkg::DIFF_W-1] ? lgi_pkg::DIFF_W'(-dividend)
                                             : lgi_pkg::DIFF_W'(dividend);

    // one restoring step: bring down the next dividend bit
    assign part = {acc_reg, quo_reg[lgi_pkg::DIFF_W-1]};
    assign fits = part >= {1'b0, divisor};

    // control of the iteration
    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = fix_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = lgi_pkg::DCNT_W'(lgi_pkg::DIFF_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lgi_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // magnitude division and floor correction for a negative dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[lgi_pkg::DIFF_W-1];
            quo_reg <= mag;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[lgi_pkg::DIFF_W-2:0], fits};
            acc_reg <= fits ? lgi_pkg::DIV_W'(part - {1'b0, divisor})
                            : lgi_pkg::DIV_W'(part);
        end
        if (fix_reg)
        begin
            if (neg_reg && (acc_reg != '0))
            begin
                quot_reg <= lgi_pkg::diff_t'(~quo_reg);
                rem_reg  <= divisor - acc_reg;
            end
            else if (neg_reg)
            begin
                quot_reg <= lgi_pkg::diff_t'(-quo_reg);
                rem_reg  <= '0;
            end
            else
            begin
                quot_reg <= lgi_pkg::diff_t'(quo_reg);
                rem_reg  <= acc_reg;
            end
        end
    end

    assign busy = busy_reg | fix_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/lgi_dp.sv
module lgi_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lgi_pkg::DATA_W-1:0]    s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lgi_pkg::DATA_W-1:0]    m_tdata,
    output logic [lgi_pkg::OUSER_W-1:0]   m_tuser,
    output logic                          m_tlast,
    input  lgi_pkg::cmd_t                 cmd,
    output lgi_pkg::stat_t                stat,
    output logic                          div_start,
    output lgi_pkg::diff_t                div_dividend,
    output lgi_pkg::divisor_t             div_divisor,
    input  logic                          div_busy,
    input  logic                          div_done,
    input  lgi_pkg::diff_t                div_quot,
    input  lgi_pkg::divisor_t             div_rem
);

    // series state
    logic                  seen_reg, seen_next;
    lgi_pkg::sample_t      anchor_reg, anchor_next;
    lgi_pkg::gap_t         pending_reg, pending_next;
    logic                  overlong_reg, overlong_next;

    // latched request
    lgi_pkg::sample_t      x_reg;
    logic                  present_reg;
    logic                  last_reg;
    logic                  tl_reg;
    lgi_pkg::diff_t        diff_reg;
    lgi_pkg::gap_t         cnt_reg;

    // fill accumulator
    lgi_pkg::diff_t        val_reg;
    lgi_pkg::divisor_t     r_reg;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [lgi_pkg::DATA_W-1:0]    out_data_reg;
    logic [lgi_pkg::OUSER_W-1:0]   out_user_reg;
    logic                          out_last_reg;

    lgi_pkg::sample_t      in_x;
    logic                  pend_max;
    lgi_pkg::divisor_t     divisor;
    logic [lgi_pkg::DIV_W:0] rsum;
    logic                  carry;
    lgi_pkg::divisor_t     r_next;
    lgi_pkg::diff_t        val_next;
    logic [lgi_pkg::DATA_W-1:0]  emit_data;
    logic [lgi_pkg::OUSER_W-1:0] emit_user;
    logic                  emit_last;

    assign in_x     = s_tdata[lgi_pkg::SAMPLE_WIDTH-1:0];
    assign pend_max = pending_reg == lgi_pkg::GAP_W'(lgi_pkg::MAX_GAP);
    assign divisor  = lgi_pkg::DIV_W'(pending_reg) + 1'b1;

    // state update on a silent count, and on the final result of a request
    always_comb
    begin
        seen_next     = seen_reg;
        anchor_next   = anchor_reg;
        pending_next  = pending_reg;
        overlong_next = overlong_reg;
        if (cmd.bump)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (cmd.commit)
        begin
            if (last_reg)
            begin
                seen_next     = 1'b0;
                anchor_next   = '0;
                pending_next  = '0;
                overlong_next = 1'b0;
            end
            else if (present_reg)
            begin
                seen_next     = 1'b1;
                anchor_next   = x_reg;
                pending_next  = '0;
                overlong_next = 1'b0;
            end
            else
            begin
                pending_next  = '0;
                overlong_next = tl_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            anchor_reg    <= '0;
            pending_reg   <= '0;
            overlong_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            anchor_reg    <= anchor_next;
            pending_reg   <= pending_next;
            overlong_reg  <= overlong_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // latch the request and the remaining result count
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg       <= in_x;
            present_reg <= s_tuser;
            last_reg    <= s_tlast;
            tl_reg      <= !s_tuser && seen_reg && (overlong_reg || (!s_tlast && pend_max));
            diff_reg    <= lgi_pkg::diff_t'($signed(in_x)) -
                           lgi_pkg::diff_t'($signed(anchor_reg));
            cnt_reg     <= pending_reg;
        end
        else if (cmd.emit)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // next filled value: add the quotient step, carry one when the remainder wraps
    assign rsum     = {1'b0, r_reg} + {1'b0, div_rem};
    assign carry    = rsum >= {1'b0, divisor};
    assign r_next   = carry ? lgi_pkg::DIV_W'(rsum - {1'b0, divisor})
                            : lgi_pkg::DIV_W'(rsum);
    assign val_next = val_reg + div_quot + lgi_pkg::diff_t'(carry);

    always_ff @(posedge clk)
    begin
        if (cmd.fill_init)
        begin
            val_reg <= lgi_pkg::diff_t'($signed(anchor_reg));
            r_reg   <= '0;
        end
        else if (cmd.emit && (cmd.kind == lgi_pkg::EK_FILL))
        begin
            val_reg <= val_next;
            r_reg   <= r_next;
        end
    end

    // result fields by kind; tuser is present, filled, too long, run last
    always_comb
    begin
        case (cmd.kind)
            lgi_pkg::EK_FILL:
            begin
                emit_data = lgi_pkg::DATA_W'(val_next[lgi_pkg::SAMPLE_WIDTH-1:0]);
                emit_user = 4'b0011;
                emit_last = 1'b0;
            end
            lgi_pkg::EK_GAP:
            begin
                emit_data = '0;
                emit_user = {1'b0, tl_reg, 2'b00};
                emit_last = 1'b0;
            end
            lgi_pkg::EK_LAST:
            begin
                emit_data = present_reg ? lgi_pkg::DATA_W'(x_reg) : '0;
                emit_user = {1'b1, tl_reg, 1'b0, present_reg};
                emit_last = last_reg;
            end
            default:
            begin
                emit_data = '0;
                emit_user = '0;
                emit_last = 1'b0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= emit_data;
            out_user_reg <= emit_user;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // divider hookup
    assign div_start    = cmd.div_start;
    assign div_dividend = diff_reg;
    assign div_divisor  = divisor;

    // status
    assign stat.seen      = seen_reg;
    assign stat.overlong  = overlong_reg;
    assign stat.pend_zero = pending_reg == '0;
    assign stat.pend_max  = pend_max;
    assign stat.cnt_one   = cnt_reg == lgi_pkg::GAP_W'(1);
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.div_done  = div_done;
    assign stat.div_busy  = div_busy;

endmodule

>>> rtl/lgi_ctrl.sv
module lgi_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_present,
    input  logic              in_last,
    input  lgi_pkg::stat_t    stat,
    output lgi_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_DIV   = 6'b000100,
        S_FILL  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_LAST  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = state_reg == S_IDLE;

    // sequencing of one request
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = lgi_pkg::EK_LAST;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (in_present)
                    begin
                        if (stat.seen && !stat.overlong && !stat.pend_zero)
                            state_next = S_START;
                        else
                            state_next = S_LAST;
                    end
                    else if (!stat.seen || stat.overlong)
                    begin
                        state_next = S_LAST;
                    end
                    else if (in_last)
                    begin
                        state_next = stat.pend_zero ? S_LAST : S_FLUSH;
                    end
                    else if (!stat.pend_max)
                    begin
                        cmd.bump = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.fill_init = 1'b1;
                    state_next    = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.kind = lgi_pkg::EK_FILL;
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.cnt_one)
                        state_next = S_LAST;
                end
            end
            S_FLUSH:
            begin
                cmd.kind = lgi_pkg::EK_GAP;
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.cnt_one)
                        state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.kind = lgi_pkg::EK_LAST;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/linear_gap_interpolation.sv
// Linear gap filler for a stream of samples, some of them missing.
// Slave channel: one request per sample; tdata carries the signed sample,
// tuser is 1 when the sample is present, tlast marks the end of a series.
// Master channel: results in order; tdata is the value (zero when missing),
// tuser holds present, filled, gap too long and last-of-request flags,
// tlast marks the final result of a series.
// A missing sample inside a short gap gives no result; it is held until the
// present sample that closes the gap arrives, which then gives n filled
// values and itself, or until the series ends or the gap grows too long.
// Sequence: a request with one result goes from acceptance straight to the
// last state; a flush of n held samples gives n gap results and then its own;
// a held missing sample only counts up the gap. A present sample closing a gap
// of n first waits for the bit-serial divider, which divides the sample
// difference by n + 1 once per gap; filled values then come one per cycle,
// unless the receiver stalls, from a running quotient and remainder.
// Reset clears the series state and empties the output register.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer holds; no request is taken until the current one is done.
module linear_gap_interpolation
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lgi_pkg::DATA_W-1:0]         s_tdata,  // sample_value
    input  logic                               s_tuser,  // sample_present
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lgi_pkg::DATA_W-1:0]         m_tdata,  // out_value
    output logic [lgi_pkg::OUSER_W-1:0]        m_tuser,  // out_present, was_filled,
                                                         // gap_too_long, run_last
    output logic                               m_tlast   // out_series_end
);

    lgi_pkg::cmd_t      cmd;
    lgi_pkg::stat_t     stat;
    logic               div_start;
    lgi_pkg::diff_t     div_dividend;
    lgi_pkg::divisor_t  div_divisor;
    logic               div_busy;
    logic               div_done;
    lgi_pkg::diff_t     div_quot;
    lgi_pkg::divisor_t  div_rem;

    // sequencer
    lgi_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_present (s_tuser),
        .in_last    (s_tlast),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath with series state and output register
    lgi_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cmd          (cmd),
        .stat         (stat),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .div_rem      (div_rem)
    );

    // floor divider for the per-gap step
    lgi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // no request is taken while the divider works
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !s_tready)
        else $error("request accepted during division");

    // a stalled result stays offered
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped under stall");

    // filled results are always marked present
    a_fill_present: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && !m_tuser[2]))
        else $error("filled result flags inconsistent");

endmodule
